### rtl/core/mpq_pkg.sv
// Shared types and constants of the minimum priority queue.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package mpq_pkg;

	localparam int CAPACITY = 128;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int NODE_W   = 16;
	localparam int DIST_W   = 32;
	localparam int OCC_W    = 8;
	localparam int S_DATA_W = NODE_W + DIST_W;
	localparam int M_DATA_W = NODE_W + DIST_W + OCC_W;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_PUSH_OK   = 2'd0,
		ST_PUSH_FULL = 2'd1,
		ST_POP_OK    = 2'd2,
		ST_POP_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT_SETUP,
		S_SHIFT,
		S_FINISH
	} fsm_state_t;

	typedef struct packed {
		logic signed [DIST_W-1:0] distance;
		logic [NODE_W-1:0]        node;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_rd;
		logic shift_setup;
		logic shift_rd;
		logic pop_commit;
		logic load_out;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic scan_done;
		logic shift_done;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

### rtl/core/min_priority_queue.sv
// Top level of the minimum priority queue: joins controller and datapath.
// Depends on mpq_pkg, mpq_ctrl and mpq_dp.
//
// Usage:
//   The slave channel takes one item per handshake: s_tuser[0] selects push
//   (0) or pop (1); a push carries node and distance in s_tdata. The master
//   channel returns one result item per input item: status in m_tuser,
//   popped node, popped distance and occupancy in m_tdata.
//   Entries are held unsorted in arrival order in a CAPACITY-deep memory
//   with one write and one registered read port.
//   A push, or a pop on an empty queue, goes straight to the finish state;
//   m_tvalid and s_tready rise together once the result register is free.
//   A pop reads every held entry once to find the minimum (one entry per
//   cycle), then moves every later entry down one place (one per cycle)
//   before its result is loaded. The memory read port sets these rates.
//   One item is in work at a time; s_tready is high while the block waits
//   for an item. The result register lets the next item be accepted while
//   an earlier result still waits; a new result waits in turn until
//   m_tready frees that register.
//   Reset empties the queue and clears the result valid; the memory needs
//   no clearing since only written entries are ever read.
`default_nettype none

module min_priority_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [mpq_pkg::S_DATA_W-1:0] s_tdata,  // item_node, item_distance
	input  wire logic                         s_tuser,  // operation
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [mpq_pkg::M_DATA_W-1:0]      m_tdata,  // out_node, out_distance, occupancy
	output logic [1:0]                        m_tuser   // status
);

	mpq_pkg::ctrl_cmd_t  cmd;
	mpq_pkg::dp_status_t sts;

	mpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mpq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (s_tdata),
		.in_op      (s_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser)
	);

endmodule

`default_nettype wire

### rtl/core/mpq_ctrl.sv
// Controller state machine of the minimum priority queue.
// Depends on mpq_pkg; drives the datapath through command and status structs.
`default_nettype none

module mpq_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_op,
	output logic                     in_ready,
	input  wire mpq_pkg::dp_status_t sts,
	output mpq_pkg::ctrl_cmd_t       cmd
);

	mpq_pkg::fsm_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mpq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_op == mpq_pkg::OP_PUSH || sts.empty) begin
						state_d = mpq_pkg::S_FINISH;
					end else begin
						state_d = mpq_pkg::S_SCAN;
					end
				end
			end
			mpq_pkg::S_SCAN: begin
				cmd.scan_rd = 1'b1;
				// last compare happens in the cycle no read is issued
				if (sts.scan_done) begin
					state_d = mpq_pkg::S_SHIFT_SETUP;
				end
			end
			mpq_pkg::S_SHIFT_SETUP: begin
				cmd.shift_setup = 1'b1;
				state_d         = mpq_pkg::S_SHIFT;
			end
			mpq_pkg::S_SHIFT: begin
				cmd.shift_rd = 1'b1;
				if (sts.shift_done) begin
					cmd.pop_commit = 1'b1;
					state_d        = mpq_pkg::S_FINISH;
				end
			end
			mpq_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = mpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mpq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/mpq_dp.sv
// Datapath of the minimum priority queue: entry memory, count, scan and
// shift pipeline, result register. Depends on mpq_pkg; driven by mpq_ctrl.
`default_nettype none

module mpq_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [mpq_pkg::S_DATA_W-1:0]      in_data,
	input  wire logic                              in_op,
	input  wire mpq_pkg::ctrl_cmd_t                cmd,
	output mpq_pkg::dp_status_t                    sts,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [mpq_pkg::M_DATA_W-1:0]           out_data,
	output logic [1:0]                             out_status
);

	mpq_pkg::entry_t mem [mpq_pkg::CAPACITY];

	logic [mpq_pkg::CNT_W-1:0]         count_q;
	logic [mpq_pkg::CNT_W-1:0]         rd_idx_q;
	logic                              rd_vld_s1;
	logic [mpq_pkg::IDX_W-1:0]         cmp_idx_s1;
	mpq_pkg::entry_t                   rd_data_s1;
	logic [mpq_pkg::IDX_W-1:0]         best_idx_q;
	logic signed [mpq_pkg::DIST_W-1:0] best_dist_q;
	logic [mpq_pkg::NODE_W-1:0]        best_node_q;
	mpq_pkg::status_t                  status_q;
	logic                              out_valid_q;
	logic [mpq_pkg::M_DATA_W-1:0]      out_data_q;
	logic [1:0]                        out_status_q;

	logic                              full;
	logic                              rd_more;
	logic                              rd_issue;
	logic                              push_wr;
	logic                              shift_wr;
	logic                              mem_we;
	logic [mpq_pkg::IDX_W-1:0]         mem_waddr;
	mpq_pkg::entry_t                   mem_wdata;
	mpq_pkg::entry_t                   in_entry;
	logic                              take_best;

	assign full     = (count_q == mpq_pkg::CNT_W'(mpq_pkg::CAPACITY));
	assign rd_more  = (rd_idx_q < count_q);
	assign rd_issue = (cmd.scan_rd || cmd.shift_rd) && rd_more;
	assign push_wr  = cmd.accept && (in_op == mpq_pkg::OP_PUSH) && !full;
	assign shift_wr = cmd.shift_rd && rd_vld_s1;
	assign in_entry = '{distance: in_data[mpq_pkg::S_DATA_W-1:mpq_pkg::NODE_W],
		node: in_data[mpq_pkg::NODE_W-1:0]};

	// Select the single write port: append on push, move down on shift
	always_comb begin
		mem_we    = push_wr || shift_wr;
		mem_waddr = count_q[mpq_pkg::IDX_W-1:0];
		mem_wdata = in_entry;
		if (shift_wr) begin
			mem_waddr = cmp_idx_s1 - 1'b1;
			mem_wdata = rd_data_s1;
		end
	end

	// Entry memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[rd_idx_q[mpq_pkg::IDX_W-1:0]];
			cmp_idx_s1 <= rd_idx_q[mpq_pkg::IDX_W-1:0];
		end
	end

	// Strictly smaller wins, so the earliest entry is kept on ties
	assign take_best = cmd.scan_rd && rd_vld_s1 &&
		((cmp_idx_s1 == '0) || (rd_data_s1.distance < best_dist_q));

	// Hold the running minimum and the item status
	always_ff @(posedge clk) begin
		if (take_best) begin
			best_idx_q  <= cmp_idx_s1;
			best_dist_q <= rd_data_s1.distance;
			best_node_q <= rd_data_s1.node;
		end
		if (cmd.accept) begin
			if (in_op == mpq_pkg::OP_PUSH) begin
				status_q <= full ? mpq_pkg::ST_PUSH_FULL : mpq_pkg::ST_PUSH_OK;
			end else begin
				status_q <= mpq_pkg::ST_POP_EMPTY;
			end
		end else if (cmd.pop_commit) begin
			status_q <= mpq_pkg::ST_POP_OK;
		end
	end

	// Count, read pointer and read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (push_wr) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop_commit) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.accept) begin
				rd_idx_q <= '0;
			end else if (cmd.shift_setup) begin
				rd_idx_q <= mpq_pkg::CNT_W'(best_idx_q) + 1'b1;
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Result register: load when free, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= status_q;
			if (status_q == mpq_pkg::ST_POP_OK) begin
				out_data_q <= {mpq_pkg::OCC_W'(count_q), best_dist_q, best_node_q};
			end else begin
				out_data_q <= {mpq_pkg::OCC_W'(count_q),
					{(mpq_pkg::DIST_W + mpq_pkg::NODE_W){1'b0}}};
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_data       = out_data_q;
	assign out_status     = out_status_q;

	assign sts.empty      = (count_q == '0);
	assign sts.scan_done  = !rd_more;
	assign sts.shift_done = !rd_more && !rd_vld_s1;
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

`default_nettype wire

### rtl/core/mpq_checker.sv
// Port checker for min_priority_queue, bound to the top level below.
// Depends on mpq_pkg; watches the ports only.
`default_nettype none

module mpq_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_tvalid,
	input wire logic                         s_tready,
	input wire logic                         m_tvalid,
	input wire logic                         m_tready,
	input wire logic [mpq_pkg::M_DATA_W-1:0] m_tdata,
	input wire logic [1:0]                   m_tuser
);

	localparam int PAY_W = mpq_pkg::NODE_W + mpq_pkg::DIST_W;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only one item in work: ready drops after an acceptance
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	// Empty pop reports an empty queue
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == mpq_pkg::ST_POP_EMPTY |->
			m_tdata[mpq_pkg::M_DATA_W-1:PAY_W] == '0)
		else $error("empty pop with non-zero occupancy");

	// Dropped push reports a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == mpq_pkg::ST_PUSH_FULL |->
			m_tdata[mpq_pkg::M_DATA_W-1:PAY_W] == mpq_pkg::OCC_W'(mpq_pkg::CAPACITY))
		else $error("dropped push while not full");

	// Only a successful pop carries an entry
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != mpq_pkg::ST_POP_OK |-> m_tdata[PAY_W-1:0] == '0)
		else $error("entry fields set without a pop");

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

### test/min_priority_queue_test.sv
// Self-checking testbench for the minimum priority queue (min_priority_queue).
// Depends on mpq_pkg and the RTL only: it drives pushes and pops, keeps its
// own copy of the queue and compares every result item against it.
`default_nettype none

module min_priority_queue_test;

	localparam int ITEM_TOTAL = 1450;
	localparam int MAX_SHOWN  = 10;

	typedef struct {
		mpq_pkg::status_t                  status;
		logic [mpq_pkg::NODE_W-1:0]        node;
		logic signed [mpq_pkg::DIST_W-1:0] distance;
		logic [mpq_pkg::OCC_W-1:0]         occ;
	} pq_result_t;

	// Mirror of the queue contents plus the results still owed by the block
	class pq_result_board;
		mpq_pkg::entry_t held_entries[$];
		pq_result_t      due_results[$];
		int              mismatches;

		// Apply one accepted item to the mirror and queue its result
		function void note_request(logic op, logic [mpq_pkg::NODE_W-1:0] node,
				logic signed [mpq_pkg::DIST_W-1:0] distance);
			pq_result_t      r;
			mpq_pkg::entry_t e;
			int              best;
			r.status   = mpq_pkg::ST_PUSH_OK;
			r.node     = '0;
			r.distance = '0;
			if (op == mpq_pkg::OP_PUSH) begin
				if (held_entries.size() >= mpq_pkg::CAPACITY) begin
					r.status = mpq_pkg::ST_PUSH_FULL;
				end else begin
					e.node     = node;
					e.distance = distance;
					held_entries.push_back(e);
				end
			end else if (held_entries.size() == 0) begin
				r.status = mpq_pkg::ST_POP_EMPTY;
			end else begin
				// earliest entry wins on equal distances
				best = 0;
				for (int i = 1; i < held_entries.size(); i++) begin
					if (held_entries[i].distance < held_entries[best].distance)
						best = i;
				end
				r.status   = mpq_pkg::ST_POP_OK;
				r.node     = held_entries[best].node;
				r.distance = held_entries[best].distance;
				held_entries.delete(best);
			end
			r.occ = mpq_pkg::OCC_W'(held_entries.size());
			due_results.push_back(r);
		endfunction

		// Compare one result item with the oldest owed result
		function void check_response(logic [1:0] st,
				logic [mpq_pkg::M_DATA_W-1:0] data);
			pq_result_t want;
			pq_result_t got;
			got.status   = mpq_pkg::status_t'(st);
			got.node     = data[mpq_pkg::NODE_W-1:0];
			got.distance = data[mpq_pkg::NODE_W+mpq_pkg::DIST_W-1:mpq_pkg::NODE_W];
			got.occ      = data[mpq_pkg::M_DATA_W-1:mpq_pkg::NODE_W+mpq_pkg::DIST_W];
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result item: status %s node %0d dist %0d occ %0d",
						got.status.name(), got.node, got.distance, got.occ);
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status || got.node !== want.node ||
					got.distance !== want.distance || got.occ !== want.occ) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("mismatch: want %s/%0d/%0d/%0d got %s/%0d/%0d/%0d",
						want.status.name(), want.node, want.distance, want.occ,
						got.status.name(), got.node, got.distance, got.occ);
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [mpq_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic                         s_tuser = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [mpq_pkg::M_DATA_W-1:0] m_tdata;
	logic [1:0]                   m_tuser;

	pq_result_board board;
	int             items_sent;
	int             burst_left;
	int             rx_mode = 0;
	int             rx_left = 0;

	min_priority_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Run limit: far above the slowest correct run
	initial begin
		#5_000_000;
		$display("[min_priority_queue] ERROR");
		$finish;
	end

	// Stall the result side in modes: free-running, random, held off, toggling
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(4, 40);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= 1'b0;
			default: m_tready <= ~m_tready;
		endcase
	end

	// Check each result item as it leaves the block
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_response(m_tuser, m_tdata);
	end

	// Distance mix: wide random, narrow band for ties, and the extremes
	function automatic logic [mpq_pkg::DIST_W-1:0] pick_distance();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3, 4: return $urandom;
			5, 6, 7: return mpq_pkg::DIST_W'($urandom_range(0, 8)) - mpq_pkg::DIST_W'(4);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
		endcase
	endfunction

	// Offer one item; open a new burst, possibly after a gap, when one ends
	task automatic send_item(input logic op, input logic [mpq_pkg::NODE_W-1:0] node,
			input logic [mpq_pkg::DIST_W-1:0] distance);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {distance, node};
		do @(posedge clk); while (!s_tready);
		board.note_request(op, node, distance);
		items_sent++;
	endtask

	initial begin
		int phase_kind;
		int phase_len;
		int push_pct;
		int k;
		board      = new();
		items_sent = 0;
		burst_left = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, field extremes, equal distances, drain past empty
		send_item(mpq_pkg::OP_POP, 16'hffff, 32'hffff_ffff);
		send_item(mpq_pkg::OP_PUSH, 16'hffff, 32'h7fff_ffff);
		send_item(mpq_pkg::OP_PUSH, 16'h0000, 32'h8000_0000);
		send_item(mpq_pkg::OP_PUSH, 16'h5a5a, 32'hffff_ffff);
		send_item(mpq_pkg::OP_PUSH, 16'ha5a5, 32'h0000_0000);
		send_item(mpq_pkg::OP_PUSH, 16'h0001, 32'hffff_ffff);
		send_item(mpq_pkg::OP_PUSH, 16'h0002, 32'h0000_0001);
		for (k = 0; k < 7; k++)
			send_item(mpq_pkg::OP_POP, 16'($urandom), $urandom);

		// Random phases: push-heavy toward full, pop-heavy toward empty, then a mixed stretch
		phase_kind = 0;
		while (items_sent < ITEM_TOTAL) begin
			case (phase_kind)
				0: begin
					push_pct  = 90;
					phase_len = $urandom_range(150, 300);
				end
				1: begin
					push_pct  = 10;
					phase_len = $urandom_range(150, 300);
				end
				default: begin
					push_pct  = 50;
					phase_len = $urandom_range(20, 200);
				end
			endcase
			for (k = 0; k < phase_len && items_sent < ITEM_TOTAL; k++) begin
				if ($urandom_range(1, 100) <= push_pct)
					send_item(mpq_pkg::OP_PUSH, 16'($urandom), pick_distance());
				else
					send_item(mpq_pkg::OP_POP, 16'($urandom), $urandom);
			end
			phase_kind = (phase_kind + 1) % 3;
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then wait long enough for one more pop
		while (board.pending() != 0) @(posedge clk);
		repeat (2 * mpq_pkg::CAPACITY + 16) @(posedge clk);

		if (board.mismatches == 0)
			$display("[min_priority_queue] OK");
		else
			$display("[min_priority_queue] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
